// ===== hdl/hfe_pkg.sv =====
// ============================================================================
// hfe_pkg
// Shared constants, configuration indexes and pipeline slot types for the
// heart fractal escape-time core.
// ============================================================================
package hfe_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 26;
    localparam int ITER_BITS  = 10;
    localparam int VAL_W      = FRAC_BITS + 6;
    localparam int STEP_W     = 31;
    localparam int ORIG_W     = 32;
    localparam int CFG_W      = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int TAG_W      = 2;

    localparam logic [STEP_W-1:0]    STEP_RST = STEP_W'(268435);
    localparam logic [ORIG_W-1:0]    RE_RST   = ORIG_W'(-134217728);
    localparam logic [ORIG_W-1:0]    IM_RST   = ORIG_W'(-100663296);
    localparam logic [ITER_BITS-1:0] ITER_RST = ITER_BITS'(60);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PIXEL_STEP  = 2'd0,
        CFG_REAL_ORIGIN = 2'd1,
        CFG_IMAG_ORIGIN = 2'd2,
        CFG_MAX_ITER    = 2'd3
    } hfe_cfg_idx_t;

    // One pixel in flight around the iteration ring
    typedef struct packed {
        logic                    valid;
        logic                    done;
        logic [TAG_W-1:0]        tag;
        logic [COORD_BITS-1:0]   x;
        logic [COORD_BITS-1:0]   y;
        logic signed [VAL_W-1:0] c_re;
        logic signed [VAL_W-1:0] c_im;
        logic signed [VAL_W-1:0] zr;
        logic signed [VAL_W-1:0] zi;
        logic [ITER_BITS-1:0]    cnt;
    } hfe_slot_t;

    typedef struct packed {
        hfe_slot_t          slot;
        logic [2*VAL_W-1:0] p_rr;
        logic [2*VAL_W-1:0] p_ii;
        logic [2*VAL_W-1:0] p_ri;
        logic               ri_neg;
    } hfe_mul_t;

    typedef struct packed {
        hfe_slot_t slot;
        logic      step;
        logic      esc;
    } hfe_upd_t;

endpackage

// ===== hdl/hfe_in_if.sv =====
// ============================================================================
// hfe_in_if
// Pixel request channel: valid/ready with pixel coordinates.
// ============================================================================
interface hfe_in_if import hfe_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;

    modport source (output valid, pixel_x, pixel_y, input ready);
    modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

// ===== hdl/hfe_out_if.sv =====
// ============================================================================
// hfe_out_if
// Result channel: valid/ready with iteration count and pixel coordinates.
// ============================================================================
interface hfe_out_if import hfe_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [ITER_BITS-1:0]  iteration_count;
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;

    modport source (output valid, iteration_count, out_x, out_y, input ready);
    modport sink   (input valid, iteration_count, out_x, out_y, output ready);
endinterface

// ===== hdl/heart_fractal_escape_time_core.sv =====
// ============================================================================
// heart_fractal_escape_time_core
// Escape-time iteration of the heart fractal in Q6.26 fixed point, run on a
// three-stage recirculating ring that interleaves up to three pixels.
// ============================================================================
//
//  channel     dir  handshake        payload
//  pixel_in    in   valid / ready    pixel_x, pixel_y
//  result_out  out  valid / ready    iteration_count, out_x, out_y
//  cfg         in   cfg_we           cfg_addr, cfg_wdata
//
//  Each ring pass runs through multiply, update and count. A pixel
//  makes n+1 passes if it escapes after n iterations, n passes if it hits a
//  nonzero limit n, one pass for a zero limit, and also goes through the
//  mapping and output registers; up to three pixels share the ring.
//  rst_n clears all valid bits and loads the register reset values.
//  A result waiting on the output or on older pixels keeps circling the ring.
//
module heart_fractal_escape_time_core
    import hfe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    hfe_in_if.sink                pixel_in,
    hfe_out_if.source             result_out
);

    localparam int PROD_W = COORD_BITS + STEP_W;
    localparam int MAP_W  = ((PROD_W > VAL_W) ? PROD_W : VAL_W) + 2;
    localparam int SUM_W  = VAL_W + 2;
    localparam logic [2*VAL_W-1:0] VMAX_P = {{(VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W:0]     FOUR   = (VAL_W+1)'(4) << FRAC_BITS;

    // Configuration registers
    logic [STEP_W-1:0]        step_reg;
    logic signed [ORIG_W-1:0] re_org_reg;
    logic signed [ORIG_W-1:0] im_org_reg;
    logic [ITER_BITS-1:0]     max_iter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= STEP_RST;
            re_org_reg   <= RE_RST;
            im_org_reg   <= IM_RST;
            max_iter_reg <= ITER_RST;
        end
        else if (cfg_we)
        begin
            case (hfe_cfg_idx_t'(cfg_addr))
                CFG_PIXEL_STEP:  step_reg     <= cfg_wdata[STEP_W-1:0];
                CFG_REAL_ORIGIN: re_org_reg   <= cfg_wdata[ORIG_W-1:0];
                CFG_IMAG_ORIGIN: im_org_reg   <= cfg_wdata[ORIG_W-1:0];
                CFG_MAX_ITER:    max_iter_reg <= cfg_wdata[ITER_BITS-1:0];
                default:         max_iter_reg <= max_iter_reg;
            endcase
        end
    end

    function automatic logic signed [VAL_W-1:0] clamp_map(input logic signed [MAP_W-1:0] v);
        logic signed [MAP_W-1:0] hi;
        logic signed [MAP_W-1:0] lo;
        hi = MAP_W'($signed({1'b0, {(VAL_W-1){1'b1}}}));
        lo = -hi - MAP_W'(1);
        if (v > hi)
            return VAL_W'(hi);
        else if (v < lo)
            return VAL_W'(lo);
        else
            return VAL_W'(v);
    endfunction

    function automatic logic signed [VAL_W-1:0] clamp_sum(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'($signed({1'b0, {(VAL_W-1){1'b1}}}));
        lo = -hi - SUM_W'(1);
        if (v > hi)
            return VAL_W'(hi);
        else if (v < lo)
            return VAL_W'(lo);
        else
            return VAL_W'(v);
    endfunction

    function automatic logic [VAL_W-1:0] mag(input logic signed [VAL_W-1:0] v);
        return v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
    endfunction

    // Scale a product down to Q format and cap at the largest value
    function automatic logic [VAL_W-1:0] scale_q(input logic [2*VAL_W-1:0] p);
        logic [2*VAL_W-1:0] s;
        s = p >> FRAC_BITS;
        return (s > VMAX_P) ? VMAX_P[VAL_W-1:0] : s[VAL_W-1:0];
    endfunction

    // Ring, output and mapping registers
    hfe_mul_t                s1_reg, s1_next;
    hfe_upd_t                s2_reg, s2_next;
    hfe_slot_t               s3_reg, s3_next;
    logic                    prep_valid_reg;
    logic [COORD_BITS-1:0]   prep_x_reg, prep_y_reg;
    logic signed [VAL_W-1:0] prep_re_reg, prep_im_reg;
    logic signed [VAL_W-1:0] map_re, map_im;
    logic [TAG_W-1:0]        ins_tag_reg, ret_tag_reg;
    logic                    out_valid_reg;
    logic [ITER_BITS-1:0]    out_cnt_reg;
    logic [COORD_BITS-1:0]   out_x_reg, out_y_reg;

    logic      retire, insert, in_acc;
    hfe_slot_t entry;

    // Map pixel to complex point
    always_comb
    begin
        logic [PROD_W-1:0] px_prod;
        logic [PROD_W-1:0] py_prod;
        px_prod = PROD_W'(pixel_in.pixel_x) * PROD_W'(step_reg);
        py_prod = PROD_W'(pixel_in.pixel_y) * PROD_W'(step_reg);
        map_re = clamp_map($signed(MAP_W'(px_prod)) + MAP_W'(re_org_reg));
        map_im = clamp_map($signed(MAP_W'(py_prod)) + MAP_W'(im_org_reg));
    end

    assign retire = s3_reg.valid && s3_reg.done && (s3_reg.tag == ret_tag_reg)
                    && (!out_valid_reg || result_out.ready);
    assign insert = prep_valid_reg && (!s3_reg.valid || retire);
    assign in_acc = pixel_in.valid && pixel_in.ready;
    assign pixel_in.ready = !prep_valid_reg || insert;

    // Pick ring entry: fresh pixel, recirculated slot or bubble
    always_comb
    begin
        entry = s3_reg;
        if (insert)
        begin
            entry.valid = 1'b1;
            entry.done  = (max_iter_reg == '0);
            entry.tag   = ins_tag_reg;
            entry.x     = prep_x_reg;
            entry.y     = prep_y_reg;
            entry.c_re  = prep_re_reg;
            entry.c_im  = prep_im_reg;
            entry.zr    = prep_re_reg;
            entry.zi    = prep_im_reg;
            entry.cnt   = '0;
        end
        else if (retire)
        begin
            entry.valid = 1'b0;
        end
    end

    // Stage 1: squares and cross product of magnitudes
    always_comb
    begin
        logic [VAL_W-1:0] mr;
        logic [VAL_W-1:0] mi;
        mr = mag(entry.zr);
        mi = mag(entry.zi);
        s1_next.slot   = entry;
        s1_next.p_rr   = (2*VAL_W)'(mr) * (2*VAL_W)'(mr);
        s1_next.p_ii   = (2*VAL_W)'(mi) * (2*VAL_W)'(mi);
        s1_next.p_ri   = (2*VAL_W)'(mr) * (2*VAL_W)'(mi);
        s1_next.ri_neg = entry.zi[VAL_W-1];
    end

    // Stage 2: escape test and new z
    always_comb
    begin
        logic [VAL_W-1:0]        zr2;
        logic [VAL_W-1:0]        zi2;
        logic [VAL_W-1:0]        tm;
        logic signed [VAL_W-1:0] t;
        logic                    esc;
        logic                    act;
        zr2 = scale_q(s1_reg.p_rr);
        zi2 = scale_q(s1_reg.p_ii);
        tm  = scale_q(s1_reg.p_ri);
        t   = s1_reg.ri_neg ? $signed(-tm) : $signed(tm);
        esc = ((VAL_W+1)'(zr2) + (VAL_W+1)'(zi2)) > FOUR;
        act = s1_reg.slot.valid && !s1_reg.slot.done;
        s2_next.slot = s1_reg.slot;
        s2_next.step = act && !esc;
        s2_next.esc  = act && esc;
        if (act && !esc)
        begin
            s2_next.slot.zi = clamp_sum(SUM_W'(t) + SUM_W'(t) + SUM_W'(s1_reg.slot.c_im));
            s2_next.slot.zr = clamp_sum($signed(SUM_W'(zr2)) - $signed(SUM_W'(zi2))
                                        + SUM_W'(s1_reg.slot.c_re));
        end
    end

    // Stage 3: count the iteration and mark finished pixels
    always_comb
    begin
        s3_next = s2_reg.slot;
        if (s2_reg.esc)
        begin
            s3_next.done = 1'b1;
        end
        else if (s2_reg.step)
        begin
            s3_next.cnt  = s2_reg.slot.cnt + ITER_BITS'(1);
            s3_next.done = (s3_next.cnt == max_iter_reg);
        end
    end

    // Advance ring, mapping and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg.slot.valid <= 1'b0;
            s2_reg.slot.valid <= 1'b0;
            s3_reg.valid      <= 1'b0;
            prep_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
            ins_tag_reg       <= '0;
            ret_tag_reg       <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            if (in_acc)
            begin
                prep_valid_reg <= 1'b1;
                prep_x_reg     <= pixel_in.pixel_x;
                prep_y_reg     <= pixel_in.pixel_y;
                prep_re_reg    <= map_re;
                prep_im_reg    <= map_im;
            end
            else if (insert)
            begin
                prep_valid_reg <= 1'b0;
            end
            if (insert)
                ins_tag_reg <= ins_tag_reg + TAG_W'(1);
            if (retire)
            begin
                ret_tag_reg   <= ret_tag_reg + TAG_W'(1);
                out_valid_reg <= 1'b1;
                out_cnt_reg   <= s3_reg.cnt;
                out_x_reg     <= s3_reg.x;
                out_y_reg     <= s3_reg.y;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.iteration_count = out_cnt_reg;
    assign result_out.out_x           = out_x_reg;
    assign result_out.out_y           = out_y_reg;

    // Ring occupancy matches the outstanding tag window
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones({s1_reg.slot.valid, s2_reg.slot.valid, s3_reg.valid})
            == 32'(TAG_W'(ins_tag_reg - ret_tag_reg)))
        else $error("ring occupancy out of step with tags");

    // Retired count never passes the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        retire |-> (s3_reg.cnt <= max_iter_reg))
        else $error("iteration count above limit");

    // A retired pixel shows up at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        retire |=> out_valid_reg)
        else $error("retired pixel lost");

endmodule
